>>> hdl/mst_pkg.sv
package mst_pkg;

   // Field widths of the item channels.
   localparam int MAC_W     = 48;
   localparam int OUI_W     = 24;
   localparam int TICK_W    = 32;
   localparam int TIME_W    = 64;
   localparam int CHAN_W    = 4;
   localparam int RSSI_W    = 8;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 5;
   localparam int COUNT_W   = 6;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int FILTER_COUNT = 4;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [STATUS_W-1:0]    status_type;

   localparam csr_index_type CSR_MAX_AGE   = 3'd0;
   localparam csr_index_type CSR_FILTER_A  = 3'd1;
   localparam csr_index_type CSR_FILTER_B  = 3'd2;
   localparam csr_index_type CSR_FILTER_C  = 3'd3;
   localparam csr_index_type CSR_FILTER_D  = 3'd4;
   localparam csr_index_type CSR_FILTER_EN = 3'd5;

   localparam logic [TICK_W-1:0] MAX_AGE_RESET = 32'd840000;

   // Operation codes.
   localparam logic OP_OBSERVE = 1'b0;
   localparam logic OP_PURGE   = 1'b1;

   // Result status codes.
   localparam status_type ST_FILTERED = 3'd0;
   localparam status_type ST_UPDATED  = 3'd1;
   localparam status_type ST_ADDED    = 3'd2;
   localparam status_type ST_FULL     = 3'd3;
   localparam status_type ST_EARLY    = 3'd4;
   localparam status_type ST_PURGED   = 3'd5;

endpackage

>>> hdl/mst_req_if.sv
interface mst_req_if;
   import mst_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic [TICK_W-1:0]        ticker_ms;
   logic [MAC_W-1:0]         src_addr;
   logic [CHAN_W-1:0]        channel;
   logic signed [RSSI_W-1:0] rssi;

   modport source (output valid, operation, ticker_ms, src_addr, channel, rssi,
                   input ready);
   modport sink   (input valid, operation, ticker_ms, src_addr, channel, rssi,
                   output ready);
endinterface

>>> hdl/mst_rsp_if.sv
interface mst_rsp_if;
   import mst_pkg::*;

   logic               valid;
   logic               ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic [COUNT_W-1:0]  entry_count;
   logic [COUNT_W-1:0]  purged_count;

   modport source (output valid, status, slot, entry_count, purged_count, input ready);
   modport sink   (input valid, status, slot, entry_count, purged_count, output ready);
endinterface

>>> hdl/mac_station_table_with_aging_core.sv
// Station table with aging.
// Items arrive on req_ch (valid/ready). An observe item carries a source address,
// channel and RSSI; it is dropped when its vendor prefix matches an enabled filter,
// otherwise it refreshes the lowest matching entry or takes the lowest free slot.
// A purge item removes every entry whose stamp lies more than max_age_ms before the
// current time, which is the 32-bit ticker extended to 64 bits by counting wraps.
// Each item gives one result on rsp_ch: status, slot, entry count and purge count.
// Configuration must be written via csr_we/csr_index/csr_wdata while idle; not enforced.
// One item at a time: req_ch.ready is high only while idle. An accepted item passes
// through preparation, a scan of every slot, a drain and, for an observe item, a commit
// before its result is loaded; a filtered or too-early item goes straight to the result.
// The next item can be taken in the cycle after the result is loaded. The table scan,
// which dominates, reads one entry slot per cycle through a single comparator.
// After reset the block sweeps the valid memory, clearing every slot, and accepts
// no item meanwhile; configuration writes are taken at any time. A result waits in
// the output register while rsp_ch.ready is low, and the block may accept the next
// item meanwhile; that item's result is held back until the register is free.
module mac_station_table_with_aging_core #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   mst_req_if.sink                        req_ch,
   mst_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  mst_pkg::csr_index_type         csr_index,
   input  logic [mst_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mst_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   // Sequencer states.
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_PREP   = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;
   localparam logic [2:0] S_COMMIT = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   // Configuration registers.
   logic [TICK_W-1:0] max_age_ff;
   logic [OUI_W-1:0]  filter_oui_ff [FILTER_COUNT];
   logic [FILTER_COUNT-1:0] filter_en_ff;

   // Sequencer and item registers.
   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              eval_ff, eval_in;
   logic [IDX_W-1:0]  eval_idx_ff, eval_idx_in;
   logic              eval_last_ff, eval_last_in;
   logic              op_ff, op_in;
   logic [MAC_W-1:0]  mac_ff, mac_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic [RSSI_W-1:0] rssi_ff, rssi_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] limit_ff, limit_in;
   logic              filtered_ff, filtered_in;
   logic [TICK_W-1:0] last_ticker_ff, last_ticker_in;
   logic [TICK_W-1:0] wraps_ff, wraps_in;
   logic              hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  purged_ff, purged_in;
   status_type        res_status_ff, res_status_in;
   logic [IDX_W-1:0]  res_slot_ff, res_slot_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [COUNT_W-1:0] rsp_purged_ff, rsp_purged_in;

   // Entry memories and their registered read data.
   logic                                  valid_mem [TABLE_DEPTH];
   logic [MAC_W-1:0]                      addr_mem  [TABLE_DEPTH];
   logic [CHAN_W+RSSI_W+TIME_W-1:0]       data_mem  [TABLE_DEPTH];
   logic                                  rd_valid_ff;
   logic [MAC_W-1:0]                      rd_addr_ff;
   logic [CHAN_W+RSSI_W+TIME_W-1:0]       rd_data_ff;
   logic                                  rd_en;

   // Memory write controls.
   logic              vld_we;
   logic [IDX_W-1:0]  vld_waddr;
   logic              vld_wdata;
   logic              ent_we;
   logic              data_we;
   logic [IDX_W-1:0]  ent_waddr;

   // Shared comparator and helpers.
   logic [TIME_W-1:0] cmp_a, cmp_b;
   logic              cmp_eq, cmp_lt;
   logic [TIME_W:0]   age_diff;
   logic              req_fire, rsp_load;
   logic [TICK_W-1:0] wraps_next;
   logic              oui_hit;
   logic [31:0]       slot_wide, count_wide, purged_wide;

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign req_fire            = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.slot         = rsp_slot_ff;
   assign rsp_ch.entry_count  = rsp_count_ff;
   assign rsp_ch.purged_count = rsp_purged_ff;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff   <= MAX_AGE_RESET;
         filter_en_ff <= '0;
         for (int i = 0; i < FILTER_COUNT; i++) begin
            filter_oui_ff[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_AGE:   max_age_ff       <= csr_wdata[TICK_W-1:0];
            CSR_FILTER_A:  filter_oui_ff[0] <= csr_wdata[OUI_W-1:0];
            CSR_FILTER_B:  filter_oui_ff[1] <= csr_wdata[OUI_W-1:0];
            CSR_FILTER_C:  filter_oui_ff[2] <= csr_wdata[OUI_W-1:0];
            CSR_FILTER_D:  filter_oui_ff[3] <= csr_wdata[OUI_W-1:0];
            CSR_FILTER_EN: filter_en_ff     <= csr_wdata[FILTER_COUNT-1:0];
            default: ;
         endcase
      end
   end

   // Vendor prefix filter on the incoming address.
   always_comb begin
      oui_hit = 1'b0;
      for (int i = 0; i < FILTER_COUNT; i++) begin
         if (filter_en_ff[i] && (filter_oui_ff[i] == req_ch.src_addr[MAC_W-1:MAC_W-OUI_W])) begin
            oui_hit = 1'b1;
         end
      end
   end

   // Ticker extension: a ticker below the last one counts a wrap.
   assign wraps_next = (req_ch.ticker_ms < last_ticker_ff) ? wraps_ff + 1'b1 : wraps_ff;

   // One subtractor gives both the too-early test and the purge limit.
   assign age_diff = {1'b0, now_ff} - {{(TIME_W-TICK_W+1){1'b0}}, max_age_ff};

   // The shared comparator: address equality when observing, stamp order when purging.
   always_comb begin
      if (op_ff == OP_PURGE) begin
         cmp_a = rd_data_ff[TIME_W-1:0];
         cmp_b = limit_ff;
      end else begin
         cmp_a = {{(TIME_W-MAC_W){1'b0}}, rd_addr_ff};
         cmp_b = {{(TIME_W-MAC_W){1'b0}}, mac_ff};
      end
      cmp_eq = (cmp_a == cmp_b);
      cmp_lt = (cmp_a < cmp_b);
   end

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign slot_wide   = 32'(res_slot_ff);
   assign count_wide  = 32'(count_ff);
   assign purged_wide = 32'(purged_ff);

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      eval_in        = 1'b0;
      eval_idx_in    = scan_ff;
      eval_last_in   = 1'b0;
      op_in          = op_ff;
      mac_in         = mac_ff;
      chan_in        = chan_ff;
      rssi_in        = rssi_ff;
      now_in         = now_ff;
      limit_in       = limit_ff;
      filtered_in    = filtered_ff;
      last_ticker_in = last_ticker_ff;
      wraps_in       = wraps_ff;
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      count_in       = count_ff;
      purged_in      = purged_ff;
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      rd_en          = 1'b0;
      vld_we         = 1'b0;
      vld_waddr      = scan_ff;
      vld_wdata      = 1'b0;
      ent_we         = 1'b0;
      data_we        = 1'b0;
      ent_waddr      = hit_idx_ff;

      // Evaluate the slot read in the previous cycle.
      if (eval_ff) begin
         if (op_ff == OP_PURGE) begin
            if (rd_valid_ff && cmp_lt) begin
               vld_we    = 1'b1;
               vld_waddr = eval_idx_ff;
               vld_wdata = 1'b0;
               purged_in = purged_ff + 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end else if (rd_valid_ff) begin
            if (!hit_found_ff && cmp_eq) begin
               hit_found_in = 1'b1;
               hit_idx_in   = eval_idx_ff;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = eval_idx_ff;
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            vld_we    = 1'b1;
            vld_waddr = scan_ff;
            vld_wdata = 1'b0;
            if (scan_ff == LAST_IDX) begin
               scan_in  = '0;
               state_in = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in          = req_ch.operation;
               mac_in         = req_ch.src_addr;
               chan_in        = req_ch.channel;
               rssi_in        = req_ch.rssi;
               filtered_in    = oui_hit;
               wraps_in       = wraps_next;
               last_ticker_in = req_ch.ticker_ms;
               now_in         = {wraps_next, req_ch.ticker_ms};
               state_in       = S_PREP;
            end
         end
         S_PREP: begin
            scan_in       = '0;
            hit_found_in  = 1'b0;
            free_found_in = 1'b0;
            purged_in     = '0;
            res_slot_in   = '0;
            if (op_ff == OP_PURGE) begin
               limit_in = age_diff[TIME_W-1:0];
               if (age_diff[TIME_W]) begin
                  res_status_in = ST_EARLY;
                  state_in      = S_DONE;
               end else begin
                  res_status_in = ST_PURGED;
                  state_in      = S_SCAN;
               end
            end else if (filtered_ff) begin
               res_status_in = ST_FILTERED;
               state_in      = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_en        = 1'b1;
            eval_in      = 1'b1;
            eval_idx_in  = scan_ff;
            eval_last_in = (scan_ff == LAST_IDX);
            if (scan_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (eval_last_ff) begin
               state_in = (op_ff == OP_PURGE) ? S_DONE : S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (hit_found_ff) begin
               data_we       = 1'b1;
               ent_waddr     = hit_idx_ff;
               res_status_in = ST_UPDATED;
               res_slot_in   = hit_idx_ff;
            end else if (free_found_ff) begin
               vld_we        = 1'b1;
               vld_waddr     = free_idx_ff;
               vld_wdata     = 1'b1;
               ent_we        = 1'b1;
               data_we       = 1'b1;
               ent_waddr     = free_idx_ff;
               count_in      = count_ff + 1'b1;
               res_status_in = ST_ADDED;
               res_slot_in   = free_idx_ff;
            end else begin
               res_status_in = ST_FULL;
               res_slot_in   = '0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result register: loaded when the result is ready and the slot is free.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_purged_in = rsp_purged_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_slot_in   = slot_wide[SLOT_W-1:0];
         rsp_count_in  = count_wide[COUNT_W-1:0];
         rsp_purged_in = purged_wide[COUNT_W-1:0];
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         scan_ff        <= '0;
         eval_ff        <= 1'b0;
         eval_last_ff   <= 1'b0;
         last_ticker_ff <= '0;
         wraps_ff       <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         scan_ff        <= scan_in;
         eval_ff        <= eval_in;
         eval_last_ff   <= eval_last_in;
         last_ticker_ff <= last_ticker_in;
         wraps_ff       <= wraps_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      eval_idx_ff   <= eval_idx_in;
      op_ff         <= op_in;
      mac_ff        <= mac_in;
      chan_ff       <= chan_in;
      rssi_ff       <= rssi_in;
      now_ff        <= now_in;
      limit_ff      <= limit_in;
      filtered_ff   <= filtered_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      purged_ff     <= purged_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_purged_ff <= rsp_purged_in;
   end

   // Valid memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (vld_we) begin
         valid_mem[vld_waddr] <= vld_wdata;
      end
      if (rd_en) begin
         rd_valid_ff <= valid_mem[scan_ff];
      end
   end

   // Address memory.
   always_ff @(posedge clock) begin
      if (ent_we) begin
         addr_mem[ent_waddr] <= mac_ff;
      end
      if (rd_en) begin
         rd_addr_ff <= addr_mem[scan_ff];
      end
   end

   // Channel, strength and stamp memory.
   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[ent_waddr] <= {chan_ff, rssi_ff, now_ff};
      end
      if (rd_en) begin
         rd_data_ff <= data_mem[scan_ff];
      end
   end

   // The entry count never exceeds the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count beyond table size");

   // An accepted item always goes on to preparation.
   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_PREP)
      else $error("accepted item did not enter preparation");

   // Adding an entry raises the count by one.
   a_add_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT && !hit_found_ff && free_found_ff)
         |=> count_ff == $past(count_ff) + 1'b1)
      else $error("add did not raise the entry count");

   // No item is taken during the clearing sweep.
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ch.ready)
      else $error("item accepted during clearing sweep");

   // Only purge results report removed entries.
   a_purge_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != ST_PURGED) |-> rsp_ch.purged_count == '0)
      else $error("purge count on a non-purge result");

endmodule

>>> tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mst_pkg::*;

   localparam int  STATION_SLOTS   = 32;
   localparam int  POOL_SIZE       = 40;
   localparam int  SETTLE_CYCLES   = 40;
   localparam int  WATCHDOG_LIMIT  = 4000;
   localparam int  RANDOM_PHASES   = 8;
   localparam int  ITEMS_PER_PHASE = 130;
   localparam real CLOCK_PERIOD    = 8.0;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] entry_count;
      logic [COUNT_W-1:0] purged_count;
   } station_result_type;

   // Predicts the station table and holds the results still owed by the block.
   class station_table_predictor;
      bit                    slot_valid [STATION_SLOTS];
      bit [MAC_W-1:0]        slot_address [STATION_SLOTS];
      bit [TIME_W-1:0]       slot_stamp [STATION_SLOTS];
      bit [TICK_W-1:0]       prev_ticker;
      bit [TICK_W-1:0]       wrap_count;
      bit [TICK_W-1:0]       age_limit;
      bit [OUI_W-1:0]        prefix [FILTER_COUNT];
      bit [FILTER_COUNT-1:0] prefix_enable;
      station_result_type    owed_results [$];
      int                    mismatches;
      int                    results_checked;
      int                    status_tally [6];

      function new();
         prev_ticker   = '0;
         wrap_count    = '0;
         age_limit     = MAX_AGE_RESET;
         prefix_enable = '0;
         mismatches    = 0;
         results_checked = 0;
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         foreach (prefix[i]) prefix[i] = '0;
         foreach (status_tally[i]) status_tally[i] = 0;
      endfunction

      function void write_register(csr_index_type index, bit [CSR_DATA_W-1:0] value);
         case (index)
            CSR_MAX_AGE:   age_limit = value;
            CSR_FILTER_A:  prefix[0] = value[OUI_W-1:0];
            CSR_FILTER_B:  prefix[1] = value[OUI_W-1:0];
            CSR_FILTER_C:  prefix[2] = value[OUI_W-1:0];
            CSR_FILTER_D:  prefix[3] = value[OUI_W-1:0];
            CSR_FILTER_EN: prefix_enable = value[FILTER_COUNT-1:0];
            default: ;
         endcase
      endfunction

      // Apply one accepted item to the table and queue the result it must produce.
      function void note_item(bit op, bit [TICK_W-1:0] tick, bit [MAC_W-1:0] mac);
         station_result_type r;
         bit [TIME_W-1:0] now;
         bit [TIME_W-1:0] cutoff;
         bit              hidden;
         int              hit;
         int              free_slot;
         int              n;
         r         = '0;
         hidden    = 1'b0;
         hit       = -1;
         free_slot = -1;
         n         = 0;

         // The ticker is widened by counting every step backwards as one wrap.
         if (tick < prev_ticker) wrap_count++;
         prev_ticker = tick;
         now = {wrap_count, tick};
         r.status = ST_FILTERED;

         if (op == OP_PURGE) begin
            if (now < TIME_W'(age_limit)) begin
               r.status = ST_EARLY;
            end else begin
               cutoff = now - TIME_W'(age_limit);
               for (int i = 0; i < STATION_SLOTS; i++) begin
                  if (slot_valid[i] && slot_stamp[i] < cutoff) begin
                     slot_valid[i] = 1'b0;
                     r.purged_count++;
                  end
               end
               r.status = ST_PURGED;
            end
         end else begin
            for (int i = 0; i < FILTER_COUNT; i++)
               if (prefix_enable[i] && prefix[i] == mac[MAC_W-1:MAC_W-OUI_W]) hidden = 1'b1;
            if (!hidden) begin
               // Lowest matching slot wins; otherwise the lowest free one is taken.
               for (int i = 0; i < STATION_SLOTS; i++) begin
                  if (slot_valid[i]) begin
                     if (hit < 0 && slot_address[i] == mac) hit = i;
                  end else if (free_slot < 0) begin
                     free_slot = i;
                  end
               end
               if (hit >= 0) begin
                  r.status = ST_UPDATED;
               end else if (free_slot >= 0) begin
                  hit = free_slot;
                  slot_valid[hit]   = 1'b1;
                  slot_address[hit] = mac;
                  r.status = ST_ADDED;
               end else begin
                  r.status = ST_FULL;
               end
               if (hit >= 0) begin
                  slot_stamp[hit] = now;
                  r.slot = SLOT_W'(hit);
               end
            end
         end

         foreach (slot_valid[i]) if (slot_valid[i]) n++;
         r.entry_count = COUNT_W'(n);
         status_tally[r.status]++;
         owed_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                                 logic [COUNT_W-1:0] count, logic [COUNT_W-1:0] purged);
         station_result_type w;
         if (owed_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                     $time, status, slot);
            return;
         end
         w = owed_results.pop_front();
         results_checked++;
         compare_field("status", w.status, status);
         compare_field("slot", w.slot, slot);
         compare_field("entry_count", w.entry_count, count);
         compare_field("purged_count", w.purged_count, purged);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mst_req_if req_bus();
   mst_rsp_if rsp_bus();

   mac_station_table_with_aging_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   station_table_predictor station_table = new();

   int unsigned           sender_idle_pct = 0;
   int unsigned           receiver_stall_pct = 0;
   int unsigned           tick_step;
   int unsigned           purge_pct;
   int unsigned           jump_pct;
   bit [TICK_W-1:0]       ticker_now;
   bit [MAC_W-1:0]        mac_pool [POOL_SIZE];
   bit [CSR_DATA_W-1:0]   phase_cfg [6];
   int                    watchdog_count = 0;
   int                    items_sent = 0;

   localparam csr_index_type REG_ORDER [6] = '{CSR_MAX_AGE, CSR_FILTER_A, CSR_FILTER_B,
                                                CSR_FILTER_C, CSR_FILTER_D, CSR_FILTER_EN};

   // Clock generation.
   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Both channels are observed at the clock edge where the handshake completes.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            station_table.note_item(req_bus.operation, req_bus.ticker_ms, req_bus.src_addr);
         if (rsp_bus.valid && rsp_bus.ready)
            station_table.check_result(rsp_bus.status, rsp_bus.slot, rsp_bus.entry_count,
                                       rsp_bus.purged_count);
      end
   end

   // Watchdog on cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         watchdog_count <= 0;
      else
         watchdog_count <= watchdog_count + 1;
      if (watchdog_count >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, watchdog_count);
         $display("mac_station_table_with_aging_core test failed");
         $finish;
      end
   end

   // Write all six registers from phase_cfg, one per clock edge.
   task automatic configure();
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= REG_ORDER[i];
         csr_wdata <= phase_cfg[i];
         @(posedge clock);
         station_table.write_register(REG_ORDER[i], phase_cfg[i]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic set_config(bit [31:0] age, bit [23:0] pa, bit [23:0] pb, bit [23:0] pc,
                             bit [23:0] pd, bit [3:0] en);
      phase_cfg = '{age, 32'(pa), 32'(pb), 32'(pc), 32'(pd), 32'(en)};
      configure();
   endtask

   // Lower valid, then wait for every owed result and let the block settle.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (station_table.owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Offer one item, with a random idle gap first, and wait until it is taken.
   task automatic send_item(bit op, bit [TICK_W-1:0] tick, bit [MAC_W-1:0] mac,
                            bit [CHAN_W-1:0] chan, bit [RSSI_W-1:0] rssi);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.ticker_ms  <= tick;
      req_bus.src_addr   <= mac;
      req_bus.channel    <= chan;
      req_bus.rssi       <= rssi;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      items_sent++;
   endtask

   // Address pool for a phase; some entries carry the filtered vendor prefixes.
   task automatic fill_pool();
      for (int i = 0; i < POOL_SIZE; i++) begin
         mac_pool[i] = MAC_W'({$urandom, $urandom});
         if (i % 8 < 4) mac_pool[i][MAC_W-1:MAC_W-OUI_W] = phase_cfg[1 + i % 8][OUI_W-1:0];
      end
   endtask

   // One random item: the ticker mostly creeps forward, now and then jumps or wraps.
   task automatic random_item();
      int unsigned     pick;
      bit              op;
      bit [MAC_W-1:0]  mac;
      pick = $urandom_range(0, 99);
      if (pick < jump_pct / 2)
         ticker_now = $urandom;
      else if (pick < jump_pct)
         ticker_now = 32'hFFFF_FFFF - $urandom_range(0, tick_step);
      else
         ticker_now = ticker_now + $urandom_range(0, tick_step);
      op = ($urandom_range(0, 99) < purge_pct) ? OP_PURGE : OP_OBSERVE;
      if ($urandom_range(0, 99) < 85)
         mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
         mac = MAC_W'({$urandom, $urandom});
      send_item(op, ticker_now, mac, CHAN_W'($urandom_range(0, 14)), RSSI_W'($urandom));
   endtask

   initial begin
      idle_mode_type mode;
      bit [31:0]  ages  [RANDOM_PHASES];
      int         steps [RANDOM_PHASES];

      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_MAX_AGE;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= OP_OBSERVE;
      req_bus.ticker_ms  <= '0;
      req_bus.src_addr   <= '0;
      req_bus.channel    <= '0;
      req_bus.rssi       <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Default registers: too early, two adds at the field extremes, a refresh,
      // a purge that clears both, then a ticker wrap before a fresh add.
      send_item(OP_PURGE,   32'd10, 48'h0, 4'd0, 8'h00);
      send_item(OP_OBSERVE, 32'd20, 48'h0, 4'd0, 8'h80);
      send_item(OP_OBSERVE, 32'd30, 48'hFFFF_FFFF_FFFF, 4'd14, 8'h7F);
      send_item(OP_OBSERVE, 32'd40, 48'h0, 4'd5, 8'hFF);
      send_item(OP_PURGE,   32'hFFFF_FFF0, 48'hFFFF_FFFF_FFFF, 4'd14, 8'h7F);
      send_item(OP_OBSERVE, 32'd5, 48'h1234_5678_9ABC, 4'd9, 8'hC4);
      drain();

      // Filters a, c and d enabled, b disabled; purge right at the age boundary.
      set_config(32'd100, 24'hFF_FFFF, 24'h00_0000, 24'hA5_A5A5, 24'h5A_5A5A, 4'b1101);
      send_item(OP_OBSERVE, 32'd500, 48'hFFFF_FF00_0001, 4'd1, 8'h10);
      send_item(OP_OBSERVE, 32'd500, 48'hA5A5_A500_0000, 4'd2, 8'h20);
      send_item(OP_OBSERVE, 32'd500, 48'h5A5A_5AFF_FFFF, 4'd3, 8'h30);
      send_item(OP_OBSERVE, 32'd1000, 48'h0000_0000_0000, 4'd4, 8'hF0);
      send_item(OP_OBSERVE, 32'd1001, 48'h0000_0000_0001, 4'd8, 8'h01);
      send_item(OP_PURGE,   32'd1101, 48'h0, 4'd0, 8'h00);
      send_item(OP_OBSERVE, 32'd1150, 48'hA5A5_A400_0000, 4'd11, 8'hAA);
      drain();

      // Zero age removes every older entry; filter b catches prefix zero.
      set_config(32'd0, 24'hFF_FFFF, 24'h00_0000, 24'hA5_A5A5, 24'h5A_5A5A, 4'b0010);
      send_item(OP_OBSERVE, 32'd1190, 48'h0000_0000_0001, 4'd7, 8'h55);
      send_item(OP_PURGE,   32'd1200, 48'h0, 4'd0, 8'h00);
      send_item(OP_PURGE,   32'd1200, 48'h0, 4'd0, 8'h00);
      drain();

      // Largest age after one wrap.
      set_config(32'hFFFF_FFFF, 24'h12_3456, 24'hFE_DCBA, 24'h00_0001, 24'h80_0000, 4'b0000);
      send_item(OP_PURGE,   32'd1300, 48'h0, 4'd0, 8'h00);
      send_item(OP_OBSERVE, 32'd1400, 48'h8000_0000_0000, 4'd12, 8'h00);
      drain();

      // Random phases, each with its own registers and idle pattern.
      ages  = '{32'hFFFF_FFFF, 32'd2000, 32'd0, $urandom_range(0, 20000), 32'd500,
                $urandom, 32'd30000, MAX_AGE_RESET};
      steps = '{1000, 200, 50, 1000, 60, 1 << 20, 3000, 50000};
      ticker_now = 32'd1400;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         mode = idle_mode_type'(p % 4);
         case (mode)
            IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
            default:       begin sender_idle_pct = 9;  receiver_stall_pct = 9;  end
         endcase
         tick_step = steps[p];
         purge_pct = (p == 0) ? 5 : 10;
         jump_pct  = (p == 0) ? 0 : 2;
         set_config(ages[p], OUI_W'($urandom), OUI_W'($urandom), OUI_W'($urandom),
                    OUI_W'($urandom),
                    (p == 0) ? 4'b0000 : (p == RANDOM_PHASES - 1) ? 4'b1111
                                       : 4'($urandom_range(0, 15)));
         fill_pool();
         repeat (ITEMS_PER_PHASE) random_item();
         drain();
      end

      $display("Sent %0d items, checked %0d results, ticker wrapped %0d times.",
               items_sent, station_table.results_checked, station_table.wrap_count);
      $display("Status mix: filtered %0d, updated %0d, added %0d, full %0d, early %0d, purged %0d.",
               station_table.status_tally[ST_FILTERED], station_table.status_tally[ST_UPDATED],
               station_table.status_tally[ST_ADDED], station_table.status_tally[ST_FULL],
               station_table.status_tally[ST_EARLY], station_table.status_tally[ST_PURGED]);
      if (station_table.mismatches == 0 && station_table.owed_results.size() == 0) begin
         $display("mac_station_table_with_aging_core test passed");
      end else begin
         $display("mac_station_table_with_aging_core test failed");
      end
      $finish;
   end

endmodule

>>> mac_station_table_with_aging_core.f
hdl/mst_pkg.sv
hdl/mst_req_if.sv
hdl/mst_rsp_if.sv
hdl/mac_station_table_with_aging_core.sv
tb/testbench.sv
